### rtl/esg_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and CORDIC angle table for the sweep generator.
package esg_pkg;

    localparam int PHASE_BITS_DEF  = 40;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int SINE_STEPS_DEF  = 16;

    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PHASE_START     = 3'd0,
        REG_INCREMENT_START = 3'd1,
        REG_INCREMENT_RATIO = 3'd2,
        REG_ENVELOPE_START  = 3'd3,
        REG_ENVELOPE_RATIO  = 3'd4,
        REG_SAMPLE_TOTAL    = 3'd5
    } cfg_reg_t;

    localparam logic [31:0] RATIO_ONE   = 32'h4000_0000;
    localparam logic [30:0] AMP_ONE     = 31'h4000_0000;
    localparam logic [30:0] AMP_MAX     = 31'h7FFF_FFFF;
    localparam logic [34:0] CORDIC_GAIN = 35'd652032874;

    // controller -> datapath
    typedef struct packed {
        logic load;      // reload start values
        logic sine_init; // start CORDIC for the current phase
        logic sine_iter; // one CORDIC iteration
        logic mult;      // register products
        logic finish;    // form sample, advance state
    } esg_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic last;      // current sample is the final one
    } esg_stat_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_turns(input logic [4:0] i);
        logic [31:0] t;
        case (i)
            5'd0:  t = 32'h20000000;  5'd1:  t = 32'h12E4051E;
            5'd2:  t = 32'h09FB385B;  5'd3:  t = 32'h051111D4;
            5'd4:  t = 32'h028B0D43;  5'd5:  t = 32'h0145D7E1;
            5'd6:  t = 32'h00A2F61E;  5'd7:  t = 32'h00517C55;
            5'd8:  t = 32'h0028BE53;  5'd9:  t = 32'h00145F2F;
            5'd10: t = 32'h000A2F98;  5'd11: t = 32'h000517CC;
            5'd12: t = 32'h00028BE6;  5'd13: t = 32'h000145F3;
            5'd14: t = 32'h0000A2FA;  5'd15: t = 32'h0000517D;
            5'd16: t = 32'h000028BE;  5'd17: t = 32'h0000145F;
            5'd18: t = 32'h00000A30;  5'd19: t = 32'h00000518;
            5'd20: t = 32'h0000028C;  5'd21: t = 32'h00000146;
            5'd22: t = 32'h000000A3;  5'd23: t = 32'h00000051;
            default: t = 32'h0;
        endcase
        return t;
    endfunction

endpackage

### rtl/exponential_sweep_generator.sv
`timescale 1ns / 1ps
// Exponential sine sweep generator top level.
// Each accepted restart beat is one sample tick. A tick with restart=1 reloads the
// start registers and begins a sweep; while a sweep runs each tick yields one sample
// beat, and an idle tick without restart yields nothing. A new tick is accepted
// only once the last sample is in the output register. The CORDIC sine unit
// does one iteration per cycle. Write configuration only while idle.
module exponential_sweep_generator #(
    parameter int PHASE_BITS  = esg_pkg::PHASE_BITS_DEF,
    parameter int SAMPLE_BITS = esg_pkg::SAMPLE_BITS_DEF,
    parameter int SINE_STEPS  = esg_pkg::SINE_STEPS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [esg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_restart,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_sample,
    output logic                          m_last_sample
);
    import esg_pkg::*;

    esg_cmd_t  cmd;
    esg_stat_t stat;

    assign cfg_ready = 1'b1;

    esg_ctrl #(.SINE_STEPS(SINE_STEPS)) u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_restart,
        .m_valid, .m_ready, .cmd, .stat
    );

    esg_datapath #(
        .PHASE_BITS(PHASE_BITS), .SAMPLE_BITS(SAMPLE_BITS), .SINE_STEPS(SINE_STEPS)
    ) u_dp (
        .aclk, .aresetn, .cfg_we(cfg_valid), .cfg_index, .cfg_data,
        .cmd, .stat, .m_sample, .m_last_sample
    );

`ifndef SYNTH
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> s_ready) else $error("load outside idle");
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cmd)) else $error("overlapping commands");
    a_finish_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> m_valid) else $error("finished beat not presented");
`endif

endmodule

### rtl/esg_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: accepts a tick, runs the CORDIC iterations and the output stage.
module esg_ctrl #(
    parameter int SINE_STEPS = esg_pkg::SINE_STEPS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_restart,
    output logic                m_valid,
    input  logic                m_ready,
    output esg_pkg::esg_cmd_t   cmd,
    input  esg_pkg::esg_stat_t  stat
);
    import esg_pkg::*;

    localparam int CNT_W = $clog2(SINE_STEPS + 1);

    typedef enum logic [2:0] {S_IDLE, S_INIT, S_ITER, S_MULT, S_DONE} state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               running_reg, running_next;
    logic               m_valid_reg, m_valid_next;

    wire accept = s_valid && s_ready;
    wire out_free = !m_valid_reg || m_ready;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        running_next = running_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_restart) begin
                        cmd.load     = 1'b1;
                        running_next = 1'b1;
                        state_next   = S_INIT;
                    end else if (running_reg) begin
                        state_next = S_INIT;
                    end
                end
            end
            S_INIT: begin
                cmd.sine_init = 1'b1;
                cnt_next      = '0;
                state_next    = S_ITER;
            end
            S_ITER: begin
                cmd.sine_iter = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SINE_STEPS - 1)) state_next = S_MULT;
            end
            S_MULT: begin
                cmd.mult   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.finish   = 1'b1;
                    m_valid_next = 1'b1;
                    if (stat.last) running_next = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            running_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            running_reg <= running_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

### rtl/esg_datapath.sv
`timescale 1ns / 1ps
// Sweep state, configuration registers, CORDIC and the ratio multipliers.
module esg_datapath #(
    parameter int PHASE_BITS  = esg_pkg::PHASE_BITS_DEF,
    parameter int SAMPLE_BITS = esg_pkg::SAMPLE_BITS_DEF,
    parameter int SINE_STEPS  = esg_pkg::SINE_STEPS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [esg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data,
    input  esg_pkg::esg_cmd_t             cmd,
    output esg_pkg::esg_stat_t            stat,
    output logic signed [SAMPLE_BITS-1:0] m_sample,
    output logic                          m_last_sample
);
    import esg_pkg::*;

    localparam int SW       = PHASE_BITS + 1;
    localparam int ITER_W   = $clog2(SINE_STEPS + 1);
    localparam int OUT_SHIFT = 61 - SAMPLE_BITS;
    localparam int MW       = SW + 16;          // partial product width

    // configuration
    logic [PHASE_BITS-1:0] phase_start_reg;
    logic [SW-1:0]         increment_start_reg;
    logic [31:0]           increment_ratio_reg;
    logic [30:0]           envelope_start_reg;
    logic [31:0]           envelope_ratio_reg;
    logic [23:0]           sample_total_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_start_reg     <= '0;
            increment_start_reg <= '0;
            increment_ratio_reg <= RATIO_ONE;
            envelope_start_reg  <= AMP_ONE;
            envelope_ratio_reg  <= RATIO_ONE;
            sample_total_reg    <= 24'd1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_PHASE_START:     phase_start_reg     <= cfg_data[PHASE_BITS-1:0];
                REG_INCREMENT_START: increment_start_reg <= cfg_data[SW-1:0];
                REG_INCREMENT_RATIO: increment_ratio_reg <= cfg_data[31:0];
                REG_ENVELOPE_START:  envelope_start_reg  <= cfg_data[30:0];
                REG_ENVELOPE_RATIO:  envelope_ratio_reg  <= cfg_data[31:0];
                REG_SAMPLE_TOTAL:    sample_total_reg    <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // sweep state
    logic [PHASE_BITS-1:0] phase_reg;
    logic signed [SW-1:0]  step_reg;
    logic [30:0]           amp_reg;
    logic [23:0]           left_reg;

    // CORDIC
    logic signed [34:0] x_reg, y_reg;
    logic signed [33:0] z_reg;
    logic               flip_reg;
    logic [ITER_W-1:0]  iter_reg;

    logic [31:0] angle;
    logic [31:0] angle_f;
    logic        flip;
    generate
        if (PHASE_BITS >= 32) begin : g_shr
            assign angle = phase_reg[PHASE_BITS-1 -: 32];
        end else begin : g_shl
            assign angle = {phase_reg, {(32-PHASE_BITS){1'b0}}};
        end
    endgenerate
    assign flip    = angle[31] ^ angle[30];
    assign angle_f = flip ? angle + 32'h8000_0000 : angle;

    logic signed [34:0] dx, dy;
    logic signed [33:0] at;
    assign dx = y_reg >>> iter_reg;
    assign dy = x_reg >>> iter_reg;
    assign at = $signed({2'b00, atan_turns(5'(iter_reg))});

    // products
    logic [SW-1:0]         mag;
    logic                  neg_reg;
    logic [MW-1:0]         p_lo_reg, p_hi_reg;
    logic [62:0]           a_prod_reg;
    logic signed [66:0]    s_prod_reg;

    // magnitude keeps the full width so the most negative step stays exact
    wire step_neg = step_reg[SW-1];
    always_comb begin
        mag = step_neg ? (~step_reg + 1'b1) : step_reg;
    end

    // step rescale
    logic [MW+16:0] low_sum;
    logic [MW:0]    r_step;
    logic           sat_pos, sat_neg_hi;
    logic signed [SW-1:0] step_new;
    always_comb begin
        low_sum = {p_hi_reg[13:0], 16'h0} + (MW+17)'(p_lo_reg) + (MW+17)'(1 << 29);
        r_step  = (MW+1)'(p_hi_reg >> 14) + (MW+1)'(low_sum >> 30);
        sat_pos = r_step > (MW+1)'({(SW-1){1'b1}});
        sat_neg_hi = sat_pos;
        if (neg_reg)
            step_new = sat_neg_hi ? {1'b1, {(SW-1){1'b0}}} : -$signed(r_step[SW-1:0]);
        else
            step_new = sat_pos ? {1'b0, {(SW-1){1'b1}}} : $signed(r_step[SW-1:0]);
    end

    logic [32:0] a2;
    assign a2 = 33'((a_prod_reg + 63'(1 << 29)) >> 30);

    logic signed [66:0] s_rnd;
    logic signed [66:0] s_sh;
    logic signed [SAMPLE_BITS-1:0] smp;
    localparam logic signed [66:0] SMAX = (67'sd1 <<< (SAMPLE_BITS-1)) - 67'sd1;
    always_comb begin
        s_rnd = s_prod_reg + (67'sd1 <<< (OUT_SHIFT-1));
        s_sh  = s_rnd >>> OUT_SHIFT;
        if (s_sh > SMAX)            smp = SAMPLE_BITS'(SMAX);
        else if (s_sh < -SMAX - 1)  smp = SAMPLE_BITS'(-SMAX - 1);
        else                        smp = s_sh[SAMPLE_BITS-1:0];
    end

    assign stat.last = (left_reg <= 24'd1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
            step_reg  <= '0;
            amp_reg   <= '0;
            left_reg  <= '0;
        end else if (cmd.load) begin
            phase_reg <= phase_start_reg;
            step_reg  <= increment_start_reg;
            amp_reg   <= envelope_start_reg;
            left_reg  <= (sample_total_reg == '0) ? 24'd1 : sample_total_reg;
        end else if (cmd.finish) begin
            phase_reg <= phase_reg + step_reg[PHASE_BITS-1:0];
            step_reg  <= step_new;
            amp_reg   <= (a2 > 33'(AMP_MAX)) ? AMP_MAX : a2[30:0];
            left_reg  <= stat.last ? 24'd0 : left_reg - 24'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sine_init) begin
            x_reg    <= $signed(CORDIC_GAIN);
            y_reg    <= '0;
            z_reg    <= $signed({{2{angle_f[31]}}, angle_f});
            flip_reg <= flip;
            iter_reg <= '0;
        end else if (cmd.sine_iter) begin
            iter_reg <= iter_reg + 1'b1;
            if (!z_reg[33]) begin
                x_reg <= x_reg - dx; y_reg <= y_reg + dy; z_reg <= z_reg - at;
            end else begin
                x_reg <= x_reg + dx; y_reg <= y_reg - dy; z_reg <= z_reg + at;
            end
        end
        if (cmd.mult) begin
            neg_reg    <= step_neg;
            p_lo_reg   <= MW'(mag) * MW'(increment_ratio_reg[15:0]);
            p_hi_reg   <= MW'(mag) * MW'(increment_ratio_reg[31:16]);
            a_prod_reg <= 63'(amp_reg) * 63'(envelope_ratio_reg);
            s_prod_reg <= $signed({36'd0, amp_reg}) *
                          (flip_reg ? -67'(y_reg) : 67'(y_reg));
        end
        if (cmd.finish) begin
            m_sample      <= smp;
            m_last_sample <= stat.last;
        end
    end

endmodule

### tb/tb_exponential_sweep_generator.sv
`timescale 1ns / 1ps
// Self-checking testbench for the exponential sine sweep generator.
module tb_exponential_sweep_generator;
    import esg_pkg::*;

    localparam int  IDLE_LIMIT  = 20000;
    localparam int  SETTLE      = 40;
    localparam int  HOLD_CYCLES = 400;
    localparam logic [39:0] PHASE_MASK = 40'hFF_FFFF_FFFF;
    localparam longint STEP_MAX = 64'sd1099511627775;
    localparam longint STEP_MIN = -64'sd1099511627776;
    localparam logic [31:0] ATAN_TBL [16] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D};

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        s_valid = 0;
    logic        s_ready;
    logic        s_restart = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic signed [15:0] m_sample;
    logic        m_last_sample;

    exponential_sweep_generator uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_restart(s_restart),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_sample(m_sample), .m_last_sample(m_last_sample)
    );

    always #5 aclk = ~aclk;

    // shadow registers and sweep state
    logic [39:0] sh_phase_start;
    logic [40:0] sh_inc_start;
    logic [31:0] sh_inc_ratio;
    logic [30:0] sh_env_start;
    logic [31:0] sh_env_ratio;
    logic [23:0] sh_total;
    logic [39:0] sw_phase;
    longint      sw_step;
    logic [30:0] sw_amp;
    logic [23:0] sw_left;
    bit          sw_running;

    logic signed [15:0] want_sample_q[$];
    bit                 want_last_q[$];

    int  mismatches = 0;
    bit  quiet = 0;      // no idling on either side
    bit  hold_go = 0;
    bit  holding = 0;
    int  rx_wait = 0;
    int  idle_cycles = 0;

    function automatic longint sine_q30(logic [31:0] a);
        bit     flip;
        longint x, y, z, dx, dy;
        flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
        if (flip) a = a + 32'h8000_0000;
        x = longint'(CORDIC_GAIN);
        y = 0;
        z = longint'($signed(a));
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ATAN_TBL[i]);
            end else begin
                x += dx; y -= dy; z += longint'(ATAN_TBL[i]);
            end
        end
        return flip ? -y : y;
    endfunction

    function automatic longint scaled_step(longint step, logic [31:0] ratio);
        bit        neg;
        bit [79:0] mag, prod, r;
        neg  = step < 0;
        mag  = neg ? 80'(-step) : 80'(step);
        prod = mag * 80'(ratio);
        r    = (prod + (80'd1 << 29)) >> 30;
        if (neg) return (r > 80'(STEP_MAX)) ? STEP_MIN : -longint'(r);
        return (r > 80'(STEP_MAX)) ? STEP_MAX : longint'(r);
    endfunction

    task automatic reset_shadow();
        sh_phase_start = '0; sh_inc_start = '0;
        sh_inc_ratio = RATIO_ONE; sh_env_start = AMP_ONE;
        sh_env_ratio = RATIO_ONE; sh_total = 24'd1;
        sw_phase = '0; sw_step = 0; sw_amp = '0; sw_left = '0; sw_running = 0;
    endtask

    // advance the sweep model by one tick and queue the sample it yields
    task automatic predict_tick(bit restart);
        longint prod, smp;
        bit [63:0] a2;
        if (restart) begin
            sw_phase   = sh_phase_start;
            sw_step    = longint'($signed(sh_inc_start));
            sw_amp     = sh_env_start;
            sw_left    = (sh_total == 0) ? 24'd1 : sh_total;
            sw_running = 1;
        end
        if (!sw_running) return;
        prod = longint'(sw_amp) * sine_q30(sw_phase[39:8]);
        smp  = (prod + (64'sd1 <<< 44)) >>> 45;
        if (smp > 32767) smp = 32767;
        if (smp < -32768) smp = -32768;
        want_sample_q.push_back(16'(smp));
        want_last_q.push_back(sw_left <= 1);
        sw_phase = (sw_phase + sw_step[39:0]) & PHASE_MASK;
        sw_step  = scaled_step(sw_step, sh_inc_ratio);
        a2 = (64'(sw_amp) * 64'(sh_env_ratio) + (64'd1 << 29)) >> 30;
        sw_amp = (a2 > 64'(AMP_MAX)) ? AMP_MAX : a2[30:0];
        if (sw_left <= 1) begin
            sw_left = 0; sw_running = 0;
        end else begin
            sw_left--;
        end
    endtask

    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, 14);
    endfunction

    task automatic send_tick(bit restart);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1;
        s_restart <= restart;
        do @(posedge aclk); while (!s_ready);
        predict_tick(restart);
    endtask

    // let every pending sample arrive, then let the datapath settle
    task automatic drain();
        s_valid <= 0;
        @(posedge aclk);
        while (want_sample_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] data);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        case (idx)
            REG_PHASE_START:     sh_phase_start = data[39:0];
            REG_INCREMENT_START: sh_inc_start   = data[40:0];
            REG_INCREMENT_RATIO: sh_inc_ratio   = data[31:0];
            REG_ENVELOPE_START:  sh_env_start   = data[30:0];
            REG_ENVELOPE_RATIO:  sh_env_ratio   = data[31:0];
            REG_SAMPLE_TOTAL:    sh_total       = data[23:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic run_sweep(int n);
        send_tick(1);
        for (int i = 1; i < n; i++) send_tick(0);
    endtask

    // ---------------- tests ----------------

    task automatic test_defaults();
        send_tick(0);          // idle tick, nothing comes out
        send_tick(1);
        drain();
    endtask

    task automatic test_extremes();
        write_reg(REG_SAMPLE_TOTAL, 64'd3);
        write_reg(REG_ENVELOPE_START, 64'h7FFF_FFFF);
        foreach (ATAN_TBL[q]) if (q < 4) begin
            write_reg(REG_PHASE_START, {24'd0, 2'(q), 38'h10_0000_0000});
            run_sweep(1);
            drain();
        end
        write_reg(REG_PHASE_START, 64'hFF_FFFF_FFFF);
        write_reg(REG_INCREMENT_START, 64'h0FF_FFFF_FFFF);
        write_reg(REG_INCREMENT_RATIO, 64'hFFFF_FFFF);
        write_reg(REG_ENVELOPE_RATIO, 64'hFFFF_FFFF);
        run_sweep(4);
        drain();
        write_reg(REG_INCREMENT_START, 64'h100_0000_0000);
        write_reg(REG_INCREMENT_RATIO, 64'd0);
        write_reg(REG_ENVELOPE_RATIO, 64'd0);
        write_reg(REG_SAMPLE_TOTAL, 64'd0);       // zero total: one sample
        run_sweep(1);
        send_tick(0);
        drain();
        write_reg(3'd6, 64'hFFFF_FFFF_FFFF_FFFF); // out of range, ignored
        write_reg(3'd7, 64'd0);
        write_reg(REG_SAMPLE_TOTAL, 64'd6);
        run_sweep(3);
        run_sweep(6);                             // restart mid-sweep
        drain();
    endtask

    function automatic logic [63:0] rand_value(int idx);
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = '1;
            default: ;
        endcase
        if (idx == REG_SAMPLE_TOTAL && $urandom_range(0, 49) != 0)
            v = $urandom_range(0, 40);
        if ((idx == REG_INCREMENT_RATIO || idx == REG_ENVELOPE_RATIO)
            && $urandom_range(0, 2) == 0)
            v = {$urandom} % 64'h1000_0000 + 64'h3800_0000;   // near 1.0
        return v;
    endfunction

    task automatic test_random();
        int ticks, len;
        ticks = 0;
        while (ticks < 1850) begin
            quiet = ($urandom_range(0, 7) == 0);
            drain();
            for (int r = 0; r < 8; r++)
                if ($urandom_range(0, 2) == 0 || r == REG_SAMPLE_TOTAL)
                    write_reg(r[2:0], rand_value(r));
            len = (sh_total == 0) ? 1 : int'(sh_total);
            if (len > 60) len = 60;
            for (int i = 0; i < len; i++) begin
                send_tick(i == 0 || $urandom_range(0, 24) == 0);
                ticks++;
            end
            repeat ($urandom_range(0, 2)) begin
                send_tick($urandom_range(0, 5) == 0);
                ticks++;
            end
        end
        quiet = 0;
        drain();
    endtask

    task automatic test_backpressure();
        write_reg(REG_SAMPLE_TOTAL, 64'd30);
        hold_go = 1;
        run_sweep(30);
        drain();
    endtask

    // ---------------- receiver and checker ----------------

    always begin
        wait (hold_go);
        holding = 1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        holding = 0;
        hold_go = 0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (want_sample_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected sample beat %0d last %0b", m_sample, m_last_sample);
            end else begin
                if (m_sample !== want_sample_q[0] || m_last_sample !== want_last_q[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("sample mismatch: expected %0d last %0b, got %0d last %0b",
                                 want_sample_q[0], want_last_q[0], m_sample, m_last_sample);
                end
                void'(want_sample_q.pop_front());
                void'(want_last_q.pop_front());
            end
        end
        if (!aresetn || holding) begin
            m_ready <= 0;
        end else if (m_valid && m_ready) begin
            rx_wait = draw_gap();
            m_ready <= (rx_wait == 0);
        end else if (rx_wait > 0) begin
            rx_wait--;
            m_ready <= (rx_wait == 0);
        end else begin
            m_ready <= 1;
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        reset_shadow();
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        test_defaults();
        test_extremes();
        test_backpressure();
        test_random();
        if (mismatches == 0 && want_sample_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### exponential_sweep_generator.f
rtl/esg_pkg.sv
rtl/esg_ctrl.sv
rtl/esg_datapath.sv
rtl/exponential_sweep_generator.sv
tb/tb_exponential_sweep_generator.sv
